### rtl/five_tuple_flow_meter_unit_macros.svh
// Assertion macros for the flow meter unit
`ifndef FIVE_TUPLE_FLOW_METER_UNIT_MACROS_SVH
`define FIVE_TUPLE_FLOW_METER_UNIT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define FTFM_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define FTFM_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define FTFM_ASSERT_IMPL(label, clk, rst, ante, cons)
`define FTFM_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

### rtl/ftfm_pkg.sv
// Shared constants of the flow meter
package ftfm_pkg;
   localparam int TABLE_DEPTH_DEF = 32;
   localparam logic [15:0] INTERVAL_RESET = 16'd30;
   localparam logic [15:0] ETYPE_V4 = 16'h0800;
   localparam logic [15:0] ETYPE_V6 = 16'h86DD;
   localparam logic [7:0] PROTO_TCP = 8'd6;
   localparam logic [7:0] PROTO_UDP = 8'd17;
   localparam logic [2:0] KIND_RECORD = 3'd0;
   localparam logic [2:0] KIND_END = 3'd1;
   localparam logic [2:0] KIND_COUNTED = 3'd2;
   localparam logic [2:0] KIND_IGNORED = 3'd3;
   localparam logic [2:0] KIND_DROPPED = 3'd4;
   localparam int KEY_W = 64 * 4 + 32 + 9;
   localparam int CNT_W = 64 + 64 + 32 + 32;
endpackage

### rtl/ftfm_ram.sv
// Generic single-port-write, registered-read RAM
module ftfm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                                       clock,
   input  logic                                       wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                           wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                           rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_data <= mem[rd_addr];
   end
endmodule

### rtl/five_tuple_flow_meter_unit.sv
// Flow meter top level: sequencer over key and counter memories
//  channel | dir | handshake           | payload
//  req     | in  | req_valid/req_stall | mode, header fields, time_sec
//  rsp     | out | rsp_valid/rsp_stall | kind, last, record fields
//  csr     | in  | csr_wr_en           | interval
// One item at a time. A packet scans one entry per cycle; an export
// passes each record through a memory read, then the output register.
// Reset is synchronous and clears the fill count, timer and sequencer;
// memories need no clearing. Output stalls hold the sequencer.
module five_tuple_flow_meter_unit #(
   parameter int TABLE_DEPTH = ftfm_pkg::TABLE_DEPTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic [15:0] csr_wr_data,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_mode,
   input  logic [15:0] req_ether_type,
   input  logic [7:0]  req_ip_protocol,
   input  logic [63:0] req_src_addr_hi,
   input  logic [63:0] req_src_addr_lo,
   input  logic [63:0] req_dst_addr_hi,
   input  logic [63:0] req_dst_addr_lo,
   input  logic [15:0] req_src_port,
   input  logic [15:0] req_dst_port,
   input  logic [15:0] req_wire_length,
   input  logic [31:0] req_time_sec,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_kind,
   output logic        rsp_last,
   output logic [63:0] rsp_rec_src_hi,
   output logic [63:0] rsp_rec_src_lo,
   output logic [63:0] rsp_rec_dst_hi,
   output logic [63:0] rsp_rec_dst_lo,
   output logic [31:0] rsp_rec_ports,
   output logic [8:0]  rsp_rec_tag,
   output logic [63:0] rsp_rec_packets,
   output logic [63:0] rsp_rec_bytes,
   output logic [31:0] rsp_rec_first,
   output logic [31:0] rsp_rec_latest
);
   `include "five_tuple_flow_meter_unit_macros.svh"
   localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CW = $clog2(TABLE_DEPTH + 1);
   localparam int KW = ftfm_pkg::KEY_W;
   localparam int NW = ftfm_pkg::CNT_W;

   typedef enum logic [6:0] {
      S_IDLE  = 7'b0000001,
      S_XRD   = 7'b0000010,
      S_XOUT  = 7'b0000100,
      S_XEND  = 7'b0001000,
      S_SCAN  = 7'b0010000,
      S_UPD   = 7'b0100000,
      S_STAT  = 7'b1000000
   } state_type;

   state_type state_ff, state_in;
   logic [15:0] intv_ff, intv_in;
   logic [31:0] lexp_ff, lexp_in;
   logic [CW-1:0] used_ff, used_in;
   logic [CW-1:0] idx_ff, idx_in;
   logic flush_ff, flush_in;
   logic [KW-1:0] key_ff, key_in;
   logic [15:0] len_ff, len_in;
   logic [31:0] now_ff, now_in;
   logic valid_pkt_ff, valid_pkt_in;
   logic found_ff, found_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic [2:0] kind_ff, kind_in;
   logic last_ff, last_in;
   logic [KW-1:0] okey_ff, okey_in;
   logic [NW-1:0] ocnt_ff, ocnt_in;

   logic [AW-1:0] rd_addr, wr_addr;
   logic key_we, cnt_we;
   logic [KW-1:0] key_rd;
   logic [NW-1:0] cnt_rd, cnt_wr;
   logic out_free, accept;
   logic [KW-1:0] cur_key;
   logic v6, ok;

   ftfm_ram #(.WIDTH(KW), .DEPTH(TABLE_DEPTH)) u_key (
      .clock(clock), .wr_en(key_we), .wr_addr(wr_addr), .wr_data(key_ff),
      .rd_addr(rd_addr), .rd_data(key_rd));
   ftfm_ram #(.WIDTH(NW), .DEPTH(TABLE_DEPTH)) u_cnt (
      .clock(clock), .wr_en(cnt_we), .wr_addr(wr_addr), .wr_data(cnt_wr),
      .rd_addr(rd_addr), .rd_data(cnt_rd));

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != S_IDLE);
   assign accept = req_valid && !req_stall;
   assign v6 = (req_ether_type == ftfm_pkg::ETYPE_V6);
   assign ok = (req_ether_type == ftfm_pkg::ETYPE_V4 || v6) &&
               (req_ip_protocol == ftfm_pkg::PROTO_TCP ||
                req_ip_protocol == ftfm_pkg::PROTO_UDP);
   assign cur_key = v6 ?
      {req_src_addr_hi, req_src_addr_lo, req_dst_addr_hi, req_dst_addr_lo,
       req_src_port, req_dst_port, 1'b1, req_ip_protocol} :
      {64'd0, 32'd0, req_src_addr_lo[31:0], 64'd0, 32'd0, req_dst_addr_lo[31:0],
       req_src_port, req_dst_port, 1'b0, req_ip_protocol};
   assign rd_addr = idx_in[AW-1:0];
   assign wr_addr = idx_ff[AW-1:0];

   always_comb begin
      state_in = state_ff; intv_in = intv_ff; lexp_in = lexp_ff;
      used_in = used_ff; idx_in = idx_ff; flush_in = flush_ff;
      key_in = key_ff; len_in = len_ff; now_in = now_ff;
      valid_pkt_in = valid_pkt_ff; found_in = found_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      kind_in = kind_ff; last_in = last_ff; okey_in = okey_ff; ocnt_in = ocnt_ff;
      key_we = 1'b0; cnt_we = 1'b0;
      cnt_wr = {cnt_rd[NW-1:128] + 64'd1, cnt_rd[127:64] + {48'd0, len_ff},
                cnt_rd[63:32], now_ff};
      if (csr_wr_en) intv_in = csr_wr_data;
      case (state_ff)
         S_IDLE: begin
            idx_in = '0;
            if (accept) begin
               flush_in = req_mode; key_in = cur_key; len_in = req_wire_length;
               now_in = req_time_sec; valid_pkt_in = ok; found_in = 1'b0;
               if (req_mode || (req_time_sec >= lexp_ff &&
                   req_time_sec - lexp_ff >= {16'd0, intv_ff})) begin
                  if (!req_mode) lexp_in = req_time_sec;
                  state_in = (used_ff != '0) ? S_XRD : S_XEND;
               end else begin
                  state_in = (ok && used_ff != '0) ? S_SCAN : ok ? S_UPD : S_STAT;
               end
            end
         end
         S_XRD: state_in = S_XOUT;
         S_XOUT: if (out_free) begin
            rsp_valid_in = 1'b1; kind_in = ftfm_pkg::KIND_RECORD; last_in = 1'b0;
            okey_in = key_rd; ocnt_in = cnt_rd;
            idx_in = idx_ff + 1'b1;
            state_in = (idx_ff + 1'b1 == used_ff) ? S_XEND : S_XRD;
         end
         S_XEND: if (out_free) begin
            rsp_valid_in = 1'b1; kind_in = ftfm_pkg::KIND_END; last_in = flush_ff;
            okey_in = '0;
            ocnt_in = {{(64 - CW){1'b0}}, used_ff, 128'd0};
            used_in = '0; idx_in = '0;
            state_in = flush_ff ? S_IDLE : valid_pkt_ff ? S_UPD : S_STAT;
         end
         S_SCAN: begin
            if (key_rd == key_ff) begin
               found_in = 1'b1; state_in = S_UPD;
            end else if (idx_ff + 1'b1 == used_ff) begin
               idx_in = used_ff; state_in = S_UPD;
            end else idx_in = idx_ff + 1'b1;
         end
         S_UPD: begin
            if (found_ff) begin
               cnt_we = 1'b1; kind_in = ftfm_pkg::KIND_COUNTED;
            end else if (idx_ff < CW'(TABLE_DEPTH)) begin
               key_we = 1'b1; cnt_we = 1'b1; used_in = used_ff + 1'b1;
               cnt_wr = {64'd1, 48'd0, len_ff, now_ff, now_ff};
               kind_in = ftfm_pkg::KIND_COUNTED;
            end else kind_in = ftfm_pkg::KIND_DROPPED;
            rsp_valid_in = rsp_valid_ff && rsp_stall;
            state_in = S_STAT;
         end
         S_STAT: if (out_free) begin
            rsp_valid_in = 1'b1; last_in = 1'b1; okey_in = '0; ocnt_in = '0;
            if (!valid_pkt_ff) kind_in = ftfm_pkg::KIND_IGNORED;
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // status kind set in S_UPD must survive a pending record in the output reg
   logic [2:0] stat_ff, stat_in;
   assign stat_in = (state_ff == S_UPD) ? kind_in : stat_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE; intv_ff <= ftfm_pkg::INTERVAL_RESET; lexp_ff <= '0;
         used_ff <= '0; rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in; intv_ff <= intv_in; lexp_ff <= lexp_in;
         used_ff <= used_in; rsp_valid_ff <= rsp_valid_in;
      end
      idx_ff <= idx_in; flush_ff <= flush_in; key_ff <= key_in; len_ff <= len_in;
      now_ff <= now_in; valid_pkt_ff <= valid_pkt_in; found_ff <= found_in;
      stat_ff <= stat_in; last_ff <= last_in; okey_ff <= okey_in; ocnt_ff <= ocnt_in;
      if (state_ff == S_UPD) kind_ff <= kind_ff;
      else if (state_ff == S_STAT && out_free && valid_pkt_ff) kind_ff <= stat_ff;
      else kind_ff <= kind_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_kind = kind_ff;
   assign rsp_last = last_ff;
   assign {rsp_rec_src_hi, rsp_rec_src_lo, rsp_rec_dst_hi, rsp_rec_dst_lo,
           rsp_rec_ports, rsp_rec_tag} = okey_ff;
   assign {rsp_rec_packets, rsp_rec_bytes, rsp_rec_first, rsp_rec_latest} = ocnt_ff;

   `FTFM_ASSERT_IMPL(a_fill, clock, reset, 1'b1, used_ff <= CW'(TABLE_DEPTH))
   `FTFM_ASSERT_NEXT(a_hold, clock, reset, rsp_valid_ff && rsp_stall,
                     rsp_valid_ff && $stable(okey_ff) && $stable(kind_ff))
   `FTFM_ASSERT_IMPL(a_state, clock, reset, 1'b1, $onehot(state_ff))
endmodule
